// ----- src/assert_macros.svh -----
// Assertion macros shared by the Roman numeral encoder modules.
// No dependencies; included by each file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IRN_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define IRN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IRN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/irn_pkg.sv -----
// Shared types, constants and the microcode ROM of the Roman numeral encoder.
// No dependencies; imported by every module of the block.
package irn_pkg;

  localparam int VALUE_W   = 14;
  localparam int MAG_W     = 13;
  localparam int SYM_W     = 7;
  localparam int NUM_STEPS = 19;
  localparam int PC_W      = $clog2(NUM_STEPS);
  localparam int VALUE_MAX = 5000;

  localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
  localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
  localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

  // One control word: emit sym when value >= weight, else jump to skip.
  typedef struct packed {
    logic [MAG_W-1:0] weight;
    logic [SYM_W-1:0] sym;
    logic             sub;
    logic             rpt;
    logic [PC_W-1:0]  skip;
  } uword_t;

  typedef struct packed {
    logic             load;
    logic             sub_en;
    logic [MAG_W-1:0] weight;
  } dp_ctl_t;

  typedef struct packed {
    logic ge;
    logic eq;
    logic in_range;
  } dp_stat_t;

  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] sym;
    logic             invalid;
    logic             last;
  } emit_t;

  function automatic uword_t mk(input int w, input logic [SYM_W-1:0] s,
                                input logic sb, input logic rp, input int sk);
    uword_t u;
    u.weight = MAG_W'(w);
    u.sym    = s;
    u.sub    = sb;
    u.rpt    = rp;
    u.skip   = PC_W'(sk);
    return u;
  endfunction

  // Greedy program; subtractive pairs take two steps, the second subtracts.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      5'd0:    u = mk(1000, SYM_M, 1'b1, 1'b1, 1);
      5'd1:    u = mk(900,  SYM_C, 1'b0, 1'b0, 3);
      5'd2:    u = mk(900,  SYM_M, 1'b1, 1'b0, 3);
      5'd3:    u = mk(500,  SYM_D, 1'b1, 1'b0, 4);
      5'd4:    u = mk(400,  SYM_C, 1'b0, 1'b0, 6);
      5'd5:    u = mk(400,  SYM_D, 1'b1, 1'b0, 6);
      5'd6:    u = mk(100,  SYM_C, 1'b1, 1'b1, 7);
      5'd7:    u = mk(90,   SYM_X, 1'b0, 1'b0, 9);
      5'd8:    u = mk(90,   SYM_C, 1'b1, 1'b0, 9);
      5'd9:    u = mk(50,   SYM_L, 1'b1, 1'b0, 10);
      5'd10:   u = mk(40,   SYM_X, 1'b0, 1'b0, 12);
      5'd11:   u = mk(40,   SYM_L, 1'b1, 1'b0, 12);
      5'd12:   u = mk(10,   SYM_X, 1'b1, 1'b1, 13);
      5'd13:   u = mk(9,    SYM_I, 1'b0, 1'b0, 15);
      5'd14:   u = mk(9,    SYM_X, 1'b1, 1'b0, 15);
      5'd15:   u = mk(5,    SYM_V, 1'b1, 1'b0, 16);
      5'd16:   u = mk(4,    SYM_I, 1'b0, 1'b0, 18);
      5'd17:   u = mk(4,    SYM_V, 1'b1, 1'b0, 18);
      5'd18:   u = mk(1,    SYM_I, 1'b1, 1'b1, 18);
      default: u = mk(1,    SYM_I, 1'b1, 1'b1, 18);
    endcase
    return u;
  endfunction

endpackage

// ----- src/integer_to_roman_numeral.sv -----
// Roman numeral encoder, top level.
// Input channel value_valid/value_ready carries one signed 14-bit value per item.
// Output channel symbol_valid/symbol_ready carries one ASCII symbol per item,
// most significant first, with last set on the final symbol of the run.
// A value outside 1 to 5000 gives one item with invalid = 1, symbol = 0.
// Timing: a value is taken only when the previous run has been fully handed to
// the output register. The sequencer steps once per cycle through a 19-step
// microcode ROM unless an emitting step is stalled: each symbol and each ROM row
// checked and passed over takes a step of its own, and the first symbol comes
// after the rows passed over before it.
// A stall on symbol_ready holds the output register; a step that would emit
// waits, rows passed over still advance. The next value is accepted while the
// final symbol still waits.
// Synchronous reset clears the sequencer and the output valid; no other state.
// Depends on irn_pkg, irn_seq, irn_dp, irn_out.
module integer_to_roman_numeral (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               value_valid,
  output logic                               value_ready,
  input  logic signed [irn_pkg::VALUE_W-1:0] value,
  output logic                               symbol_valid,
  input  logic                               symbol_ready,
  output logic [irn_pkg::SYM_W-1:0]          symbol,
  output logic                               invalid,
  output logic                               last
);
  import irn_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;
  emit_t    emit;
  logic     slot_free;

  irn_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .stat        (stat),
    .slot_free   (slot_free),
    .ctl         (ctl),
    .emit        (emit)
  );

  irn_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .value (value),
    .ctl   (ctl),
    .stat  (stat)
  );

  irn_out u_out (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .slot_free    (slot_free),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol),
    .invalid      (invalid),
    .last         (last)
  );

endmodule

// ----- src/irn_dp.sv -----
// Datapath: remaining-value register, compare against the step weight, subtract.
// Depends on irn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irn_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [irn_pkg::VALUE_W-1:0]  value,
  input  irn_pkg::dp_ctl_t                    ctl,
  output irn_pkg::dp_stat_t                   stat
);
  import irn_pkg::*;

  logic [MAG_W-1:0] v;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= value[MAG_W-1:0];
    end else if (ctl.sub_en) begin
      v <= v - ctl.weight;
    end
  end

  always_comb begin
    stat.ge       = (v >= ctl.weight);
    stat.eq       = (v == ctl.weight);
    stat.in_range = !value[VALUE_W-1] && (value[MAG_W-1:0] != '0) &&
                    (value[MAG_W-1:0] <= MAG_W'(VALUE_MAX));
  end

  `IRN_ASSERT_NXT(a_dp_decreases, clk, rst, ctl.sub_en && !ctl.load, v < $past(v), "value did not decrease on subtract")

endmodule

// ----- src/irn_seq.sv -----
// Microcode sequencer: step counter, ROM fetch, conditional jumps, run control.
// Depends on irn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irn_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_ready,
  input  irn_pkg::dp_stat_t  stat,
  input  logic               slot_free,
  output irn_pkg::dp_ctl_t   ctl,
  output irn_pkg::emit_t     emit
);
  import irn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_BAD} state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            accept;
  logic            hit;
  logic            miss;
  logic            bad_out;
  logic            fin;

  always_comb begin
    uw          = ucode(pc);
    value_ready = (state == S_IDLE);
    accept      = value_valid && value_ready;
    hit         = (state == S_RUN) && stat.ge && slot_free;
    miss        = (state == S_RUN) && !stat.ge;
    bad_out     = (state == S_BAD) && slot_free;
    fin         = uw.sub && stat.eq;

    ctl.load    = accept;
    ctl.sub_en  = hit && uw.sub;
    ctl.weight  = uw.weight;

    emit.push    = hit || bad_out;
    emit.sym     = (state == S_BAD) ? SYM_NONE : uw.sym;
    emit.invalid = (state == S_BAD);
    emit.last    = (state == S_BAD) || fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pc    <= '0;
            state <= stat.in_range ? S_RUN : S_BAD;
          end
        end
        S_RUN: begin
          if (miss) begin
            pc <= uw.skip;
          end else if (hit) begin
            if (fin) begin
              state <= S_IDLE;
            end else if (!uw.rpt) begin
              pc <= pc + PC_W'(1);
            end
          end
        end
        S_BAD: begin
          if (bad_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IRN_ASSERT_IMP(a_seq_pc_range, clk, rst, state == S_RUN, pc < PC_W'(NUM_STEPS), "step counter out of program")
  `IRN_ASSERT_NXT(a_seq_last_ends, clk, rst, emit.push && emit.last, state == S_IDLE, "run continued after last item")

endmodule

// ----- src/irn_out.sv -----
// Output register: holds one result item until the receiver takes it.
// Depends on irn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irn_out (
  input  logic                             clk,
  input  logic                             rst,
  input  irn_pkg::emit_t                   emit,
  output logic                             slot_free,
  output logic                             symbol_valid,
  input  logic                             symbol_ready,
  output logic [irn_pkg::SYM_W-1:0]        symbol,
  output logic                             invalid,
  output logic                             last
);
  import irn_pkg::*;

  assign slot_free = !symbol_valid || symbol_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
    end else if (emit.push) begin
      symbol_valid <= 1'b1;
    end else if (symbol_ready) begin
      symbol_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      symbol  <= emit.sym;
      invalid <= emit.invalid;
      last    <= emit.last;
    end
  end

  `IRN_ASSERT_IMP(a_out_push_free, clk, rst, emit.push, slot_free, "push into a full output register")
  `IRN_ASSERT_IMP(a_out_invalid_form, clk, rst, symbol_valid && invalid, (symbol == SYM_NONE) && last, "invalid item not a single zero symbol")

endmodule
